// ===== design/scvm_pkg.sv =====
// Shared constants, codes and types for the stacked cell voltage monitor.
package scvm_pkg;

    // Field widths
    localparam int SAMPLE_W      = 12;
    localparam int SAMPLE_BITS_D = 12;
    localparam int GAIN_W        = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int CELL_W        = 18;
    localparam int SUM_W         = 20;
    localparam int CH_W          = 2;
    localparam int CFG_IDX_W     = 2;

    // Channel codes
    localparam logic [CH_W-1:0] CH_CELL_ONE   = 2'd0;
    localparam logic [CH_W-1:0] CH_CELL_TWO   = 2'd1;
    localparam logic [CH_W-1:0] CH_CELL_THREE = 2'd2;
    localparam logic [CH_W-1:0] CH_CURRENT    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TAP_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TAP_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TAP_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURRENT   = 2'd3;

    // Gain reset values, Q4.12
    localparam logic [GAIN_W-1:0] GAIN_TAP_ONE_RST   = 16'd6600;
    localparam logic [GAIN_W-1:0] GAIN_TAP_TWO_RST   = 16'd13200;
    localparam logic [GAIN_W-1:0] GAIN_TAP_THREE_RST = 16'd19800;
    localparam logic [GAIN_W-1:0] GAIN_CURRENT_RST   = 16'd33000;

    typedef struct packed {
        logic [GAIN_W-1:0] tap_one;
        logic [GAIN_W-1:0] tap_two;
        logic [GAIN_W-1:0] tap_three;
        logic [GAIN_W-1:0] current;
    } gain_set_t;

endpackage

// ===== design/scvm_in_if.sv =====
// Input channel: one ADC sample with its conversion done flag.
interface scvm_in_if;
    logic                          valid;
    logic                          ready;
    logic [scvm_pkg::SAMPLE_W-1:0] sample;
    logic                          conversion_done;

    modport source (output valid, output sample, output conversion_done, input ready);
    modport sink   (input valid, input sample, input conversion_done, output ready);
endinterface

// ===== design/scvm_out_if.sv =====
// Output channel: one monitored channel result with optional pack sum.
interface scvm_out_if;
    logic                               valid;
    logic                               ready;
    logic [scvm_pkg::CH_W-1:0]          channel;
    logic signed [scvm_pkg::CELL_W-1:0] channel_value;
    logic                               pack_valid;
    logic signed [scvm_pkg::SUM_W-1:0]  pack_sum;
    logic [scvm_pkg::CH_W-1:0]          next_channel;

    modport source (output valid, output channel, output channel_value, output pack_valid,
                    output pack_sum, output next_channel, input ready);
    modport sink   (input valid, input channel, input channel_value, input pack_valid,
                    input pack_sum, input next_channel, output ready);
endinterface

// ===== design/stacked_cell_voltage_monitor_unit.sv =====
// Top level of the stacked cell voltage monitor: input register, gains and core.
//
// Monitors a three-cell stack and one current channel in round-robin order
// (cell one, cell two, cell three, current). Each transfer with
// conversion_done set yields one result; a transfer with the flag clear is
// dropped with no result and no state change. The sample is scaled by the
// active channel's Q4.12 gain, lower cell voltages are subtracted for cells
// two and three, and the pack sum comes with the cell three result. The unit
// takes one item per clock unless the output stalls; the path is one input
// register, then a single 16-bit gain multiply with the cell subtraction
// into the result register. Gains come out of reset at their nominal values
// and may be rewritten through cfg_we, cfg_index and cfg_data while the unit
// is idle.
module stacked_cell_voltage_monitor_unit
#(
    parameter int SAMPLE_BITS = scvm_pkg::SAMPLE_BITS_D
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    scvm_in_if.sink                          in_ch,
    scvm_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [scvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scvm_pkg::GAIN_W-1:0]      cfg_data
);

    logic                    s1_valid_reg;
    logic [SAMPLE_BITS-1:0]  s1_raw_reg;
    logic [SAMPLE_BITS-1:0]  raw;
    logic                    core_ready;
    scvm_pkg::gain_set_t     gains;

    // Keep the low SAMPLE_BITS bits of the sample, or zero-extend it when wider
    generate
        if (SAMPLE_BITS <= scvm_pkg::SAMPLE_W)
        begin : g_narrow
            assign raw = in_ch.sample[SAMPLE_BITS-1:0];
        end
        else
        begin : g_wide
            assign raw = SAMPLE_BITS'(in_ch.sample);
        end
    endgenerate

    assign in_ch.ready = !s1_valid_reg || core_ready;

    // Input register: drop transfers without a finished conversion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid && in_ch.conversion_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_raw_reg <= raw;
        end
    end

    scvm_gain_regs u_gain_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    scvm_core
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item_raw   (s1_raw_reg),
        .item_ready (core_ready),
        .gains      (gains),
        .out_ch     (out_ch)
    );

endmodule

// ===== design/scvm_gain_regs.sv =====
// Gain configuration registers written through the plain write port.
module scvm_gain_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scvm_pkg::GAIN_W-1:0]      cfg_data,
    output scvm_pkg::gain_set_t              gains
);

    scvm_pkg::gain_set_t gains_reg;
    scvm_pkg::gain_set_t gains_next;

    // Decode the write index
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                scvm_pkg::REG_GAIN_TAP_ONE:   gains_next.tap_one   = cfg_data;
                scvm_pkg::REG_GAIN_TAP_TWO:   gains_next.tap_two   = cfg_data;
                scvm_pkg::REG_GAIN_TAP_THREE: gains_next.tap_three = cfg_data;
                scvm_pkg::REG_GAIN_CURRENT:   gains_next.current   = cfg_data;
                default:                      gains_next = gains_reg;
            endcase
        end
    end

    // Hold the gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.tap_one   <= scvm_pkg::GAIN_TAP_ONE_RST;
            gains_reg.tap_two   <= scvm_pkg::GAIN_TAP_TWO_RST;
            gains_reg.tap_three <= scvm_pkg::GAIN_TAP_THREE_RST;
            gains_reg.current   <= scvm_pkg::GAIN_CURRENT_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

// ===== design/scvm_core.sv =====
// Scaling, cell difference and pack sum with channel state and result register.
module scvm_core
#(
    parameter int SAMPLE_BITS = scvm_pkg::SAMPLE_BITS_D
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic [SAMPLE_BITS-1:0]  item_raw,
    output logic                    item_ready,
    input  scvm_pkg::gain_set_t     gains,
    scvm_out_if.source              out_ch
);

    localparam int PROD_W  = SAMPLE_BITS + scvm_pkg::GAIN_W;
    localparam int SCALE_W = PROD_W - scvm_pkg::GAIN_FRAC;

    logic [scvm_pkg::CH_W-1:0]          active_channel_reg;
    logic [scvm_pkg::CH_W-1:0]          active_channel_next;
    logic signed [scvm_pkg::CELL_W-1:0] cell_reg [3];
    logic signed [scvm_pkg::CELL_W-1:0] cell_next [3];

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [scvm_pkg::CH_W-1:0]          out_channel_reg;
    logic signed [scvm_pkg::CELL_W-1:0] out_value_reg;
    logic                               out_pack_valid_reg;
    logic signed [scvm_pkg::SUM_W-1:0]  out_pack_sum_reg;
    logic [scvm_pkg::CH_W-1:0]          out_next_channel_reg;

    logic                               take;
    logic [scvm_pkg::GAIN_W-1:0]        gain;
    logic [PROD_W-1:0]                  product;
    logic [SCALE_W-1:0]                 scaled;
    logic signed [scvm_pkg::CELL_W-1:0] scaled_cell;
    logic signed [scvm_pkg::CELL_W-1:0] value;
    logic signed [scvm_pkg::SUM_W-1:0]  sum;
    logic                               pack_valid;

    assign item_ready = !out_valid_reg || out_ch.ready;
    assign take       = item_valid && item_ready;

    // Pick the gain of the active channel
    always_comb
    begin
        unique case (active_channel_reg)
            scvm_pkg::CH_CELL_ONE:   gain = gains.tap_one;
            scvm_pkg::CH_CELL_TWO:   gain = gains.tap_two;
            scvm_pkg::CH_CELL_THREE: gain = gains.tap_three;
            default:                 gain = gains.current;
        endcase
    end

    // Scale the sample and resize it to the cell width
    assign product     = PROD_W'(item_raw) * PROD_W'(gain);
    assign scaled      = product[PROD_W-1:scvm_pkg::GAIN_FRAC];
    assign scaled_cell = scvm_pkg::CELL_W'(scaled);

    // Subtract lower cells, form pack sum, advance channel
    always_comb
    begin
        cell_next[0] = cell_reg[0];
        cell_next[1] = cell_reg[1];
        cell_next[2] = cell_reg[2];
        sum          = '0;
        pack_valid   = 1'b0;
        unique case (active_channel_reg)
            scvm_pkg::CH_CELL_ONE:
            begin
                value        = scaled_cell;
                cell_next[0] = value;
            end
            scvm_pkg::CH_CELL_TWO:
            begin
                value        = scaled_cell - cell_reg[0];
                cell_next[1] = value;
            end
            scvm_pkg::CH_CELL_THREE:
            begin
                value        = scaled_cell - (cell_reg[0] + cell_reg[1]);
                cell_next[2] = value;
                sum          = scvm_pkg::SUM_W'(cell_reg[0]) + scvm_pkg::SUM_W'(cell_reg[1])
                             + scvm_pkg::SUM_W'(value);
                pack_valid   = 1'b1;
            end
            default:
            begin
                value = scaled_cell;
            end
        endcase
        active_channel_next = active_channel_reg + 1'b1;
    end

    // Result valid: set on a new item, clear after the transfer
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Advance channel state and stored cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_channel_reg <= scvm_pkg::CH_CELL_ONE;
            cell_reg[0]        <= '0;
            cell_reg[1]        <= '0;
            cell_reg[2]        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                active_channel_reg <= active_channel_next;
                cell_reg[0]        <= cell_next[0];
                cell_reg[1]        <= cell_next[1];
                cell_reg[2]        <= cell_next[2];
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_channel_reg      <= active_channel_reg;
            out_value_reg        <= value;
            out_pack_valid_reg   <= pack_valid;
            out_pack_sum_reg     <= sum;
            out_next_channel_reg <= active_channel_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.channel       = out_channel_reg;
    assign out_ch.channel_value = out_value_reg;
    assign out_ch.pack_valid    = out_pack_valid_reg;
    assign out_ch.pack_sum      = out_pack_sum_reg;
    assign out_ch.next_channel  = out_next_channel_reg;

endmodule
